@@ src/sct_pkg.sv @@
// ============================================================================
// sct_pkg : shared constants for the sphere collision test
// Field widths, fixed-point formats and opcode values of the overlap test.
// ============================================================================
package sct_pkg;

    // Width of every packed vector field on the ports.
    localparam int FIELD_W        = 48;
    // Width of a radius field, unsigned Q7.8.
    localparam int RAD_W          = 15;
    // Default width of one coordinate lane.
    localparam int COORD_BITS_DEF = 16;
    // Axis lanes are always signed Q1.14 halfwords.
    localparam int AXIS_BITS      = 16;
    localparam int AXIS_FRAC      = 14;
    // Squared radius is aligned to the squared projection format by this shift.
    localparam int LIM_SHIFT      = 2 * AXIS_FRAC;

    // Opcodes.
    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

endpackage

@@ src/sphere_collision_test_top.sv @@
// ============================================================================
// sphere_collision_test_top : pipelined sphere overlap test
// Answers sphere-against-sphere and sphere-against-oriented-box queries.
// ============================================================================
// Each accepted word is one overlap question and yields exactly one result
// word carrying a hit flag, in the order the questions arrived. The block is
// an eight-stage pipeline with a valid bit per stage: a new question can be
// accepted on every clock unless an output stall has filled the pipeline.
// The edge that accepts a question loads the first stage, and the question
// then moves stage by stage into the output register. A stage only holds
// when the stage after it is full and stalled, so empty slots are squeezed
// out and the input keeps being accepted until the pipeline is full. The
// sustained rate is one word per cycle while the output takes every result.
// Opcode 0 compares the squared centre distance with the squared radius sum.
// Opcode 1 projects the sphere centre, relative to the box centre, on the
// three box axes, clamps each projection to the half extent, and compares
// the squared distance to the clamped point with the squared radius. All
// arithmetic is exact; axes are used exactly as given, even if they are not
// unit length or orthogonal. Coordinate lanes are COORD_BITS wide; lane bits
// beyond the 48-bit field read as zero.
module sphere_collision_test_top #(
    parameter int COORD_BITS = sct_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Question channel.
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [sct_pkg::FIELD_W-1:0] i_sphere_center,
    input  logic [sct_pkg::RAD_W-1:0]   i_sphere_radius,
    input  logic [sct_pkg::FIELD_W-1:0] i_other_center,
    input  logic [sct_pkg::RAD_W-1:0]   i_other_radius,
    input  logic [sct_pkg::FIELD_W-1:0] i_half_extents,
    input  logic [sct_pkg::FIELD_W-1:0] i_axis_one,
    input  logic [sct_pkg::FIELD_W-1:0] i_axis_two,
    input  logic [sct_pkg::FIELD_W-1:0] i_axis_three,
    // Result channel.
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_hit
);
    import sct_pkg::*;

    // Pipeline depth.
    localparam int NSTG = 8;
    // Width of all three coordinate lanes together.
    localparam int LW   = 3 * COORD_BITS;
    // Centre difference, signed.
    localparam int DW   = COORD_BITS + 1;
    // One axis product, signed.
    localparam int PW   = DW + AXIS_BITS;
    // Projection, a sum of three products, signed.
    localparam int QW   = PW + 2;
    // Squared centre difference per lane and its sum over the lanes.
    localparam int SQW  = 2 * DW;
    localparam int SDW  = SQW + 2;
    // Common width for the sphere-sphere compare.
    localparam int SCW  = (SDW > 32) ? SDW : 32;
    // Distance outside the box along one axis, unsigned.
    localparam int EW   = COORD_BITS + 18;
    // Split of that distance for the partial-product square.
    localparam int EL   = (EW + 1) / 2;
    localparam int EH   = EW - EL;
    // One squared axis distance, and the sum of the three.
    localparam int SW   = 2 * EW;
    localparam int BW   = SW + 2;
    // Squared radius aligned to the projection format.
    localparam int LMW  = 2 * RAD_W + LIM_SHIFT;
    // Common width for the sphere-box compare.
    localparam int BCW  = (BW > LMW) ? BW : LMW;

    // ------------------------------------------------------------------
    // Handshake. Each stage loads when it is empty or when the stage
    // after it moves on; the last stage is the output register.
    // ------------------------------------------------------------------
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack lanes, centre differences, radius sum.
    // ------------------------------------------------------------------
    logic [LW+FIELD_W-1:0]    w_sc_wide, w_oc_wide, w_he_wide;
    logic [LW-1:0]            w_sc, w_oc, w_he;
    logic signed [DW-1:0]     n_s1_diff [3];
    logic signed [DW-1:0]     r_s1_diff [3];
    logic signed [AXIS_BITS-1:0] n_s1_ax [3][3];
    logic signed [AXIS_BITS-1:0] r_s1_ax [3][3];
    logic [COORD_BITS-1:0]    r_s1_he [3];
    logic [RAD_W:0]           r_s1_rs;
    logic [RAD_W-1:0]         r_s1_r;
    logic                     r_s1_op;

    // Lanes past bit 47 read as zero; bits past the last lane are dropped.
    assign w_sc_wide = {{LW{1'b0}}, i_sphere_center};
    assign w_oc_wide = {{LW{1'b0}}, i_other_center};
    assign w_he_wide = {{LW{1'b0}}, i_half_extents};
    assign w_sc      = w_sc_wide[LW-1:0];
    assign w_oc      = w_oc_wide[LW-1:0];
    assign w_he      = w_he_wide[LW-1:0];

    always_comb begin
        logic signed [COORD_BITS-1:0] a;
        logic signed [COORD_BITS-1:0] b;
        for (int k = 0; k < 3; k++) begin
            a = signed'(w_sc[k*COORD_BITS +: COORD_BITS]);
            b = signed'(w_oc[k*COORD_BITS +: COORD_BITS]);
            n_s1_diff[k] = DW'(a) - DW'(b);
            n_s1_ax[0][k] = signed'(i_axis_one[k*AXIS_BITS +: AXIS_BITS]);
            n_s1_ax[1][k] = signed'(i_axis_two[k*AXIS_BITS +: AXIS_BITS]);
            n_s1_ax[2][k] = signed'(i_axis_three[k*AXIS_BITS +: AXIS_BITS]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: axis products, squared lane differences, squared radii.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] n_s2_pr [3][3];
    logic signed [PW-1:0] r_s2_pr [3][3];
    logic [SQW-1:0]       n_s2_dsq [3];
    logic [SQW-1:0]       r_s2_dsq [3];
    logic [31:0]          r_s2_rs2;
    logic [2*RAD_W-1:0]   r_s2_r2;
    logic [COORD_BITS-1:0] r_s2_he [3];
    logic                 r_s2_op;

    always_comb begin
        logic [DW-1:0] mag;
        for (int k = 0; k < 3; k++) begin
            mag = r_s1_diff[k][DW-1] ? DW'(-r_s1_diff[k]) : DW'(r_s1_diff[k]);
            n_s2_dsq[k] = SQW'(mag) * SQW'(mag);
            for (int j = 0; j < 3; j++) begin
                n_s2_pr[j][k] = PW'(r_s1_diff[k]) * PW'(r_s1_ax[j][k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: projections on the box axes, sphere-sphere distance.
    // ------------------------------------------------------------------
    logic signed [QW-1:0] n_s3_p [3];
    logic signed [QW-1:0] r_s3_p [3];
    logic [SDW-1:0]       r_s3_sd;
    logic [31:0]          r_s3_rs2;
    logic [2*RAD_W-1:0]   r_s3_r2;
    logic [COORD_BITS-1:0] r_s3_he [3];
    logic                 r_s3_op;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s3_p[j] = QW'(r_s2_pr[j][0]) + QW'(r_s2_pr[j][1]) + QW'(r_s2_pr[j][2]);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp each projection against its half extent, keeping the
    // distance outside the box; sphere-sphere verdict.
    // ------------------------------------------------------------------
    logic [EW-1:0]      n_s4_e [3];
    logic [EW-1:0]      r_s4_e [3];
    logic               r_s4_sph_hit;
    logic [2*RAD_W-1:0] r_s4_r2;
    logic               r_s4_op;

    always_comb begin
        logic signed [QW-1:0] h;
        for (int j = 0; j < 3; j++) begin
            h = signed'(QW'({r_s3_he[j], {AXIS_FRAC{1'b0}}}));
            priority if (r_s3_p[j] > h) begin
                n_s4_e[j] = EW'(r_s3_p[j] - h);
            end else if (r_s3_p[j] < -h) begin
                n_s4_e[j] = EW'(-h - r_s3_p[j]);
            end else begin
                n_s4_e[j] = '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: partial products of each squared axis distance.
    // ------------------------------------------------------------------
    logic [2*EH-1:0]    n_s5_hh [3];
    logic [EH+EL-1:0]   n_s5_hl [3];
    logic [2*EL-1:0]    n_s5_ll [3];
    logic [2*EH-1:0]    r_s5_hh [3];
    logic [EH+EL-1:0]   r_s5_hl [3];
    logic [2*EL-1:0]    r_s5_ll [3];
    logic               r_s5_sph_hit;
    logic [2*RAD_W-1:0] r_s5_r2;
    logic               r_s5_op;

    always_comb begin
        logic [EH-1:0] eh;
        logic [EL-1:0] el;
        for (int j = 0; j < 3; j++) begin
            eh = r_s4_e[j][EW-1:EL];
            el = r_s4_e[j][EL-1:0];
            n_s5_hh[j] = (2*EH)'(eh) * (2*EH)'(eh);
            n_s5_hl[j] = (EH+EL)'(eh) * (EH+EL)'(el);
            n_s5_ll[j] = (2*EL)'(el) * (2*EL)'(el);
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: assemble each square. Stage 7: sum the three squares.
    // ------------------------------------------------------------------
    logic [SW-1:0]      n_s6_sq [3];
    logic [SW-1:0]      r_s6_sq [3];
    logic               r_s6_sph_hit;
    logic [2*RAD_W-1:0] r_s6_r2;
    logic               r_s6_op;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_s6_sq[j] = (SW'(r_s5_hh[j]) << (2 * EL))
                       + (SW'(r_s5_hl[j]) << (EL + 1))
                       + SW'(r_s5_ll[j]);
        end
    end

    logic [BW-1:0]      r_s7_bd;
    logic               r_s7_sph_hit;
    logic [2*RAD_W-1:0] r_s7_r2;
    logic               r_s7_op;

    // ------------------------------------------------------------------
    // Stage 8: output register with the final verdict.
    // ------------------------------------------------------------------
    logic w_box_hit;
    logic r_s8_hit;

    assign w_box_hit = BCW'(r_s7_bd) <= (BCW'(r_s7_r2) << LIM_SHIFT);
    assign o_hit     = r_s8_hit;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_diff <= n_s1_diff;
            r_s1_ax   <= n_s1_ax;
            for (int k = 0; k < 3; k++) begin
                r_s1_he[k] <= w_he[k*COORD_BITS +: COORD_BITS];
            end
            r_s1_rs <= (RAD_W+1)'(i_sphere_radius) + (RAD_W+1)'(i_other_radius);
            r_s1_r  <= i_sphere_radius;
            r_s1_op <= i_opcode;
        end
        if (w_en[1]) begin
            r_s2_pr  <= n_s2_pr;
            r_s2_dsq <= n_s2_dsq;
            r_s2_rs2 <= 32'(r_s1_rs) * 32'(r_s1_rs);
            r_s2_r2  <= (2*RAD_W)'(r_s1_r) * (2*RAD_W)'(r_s1_r);
            r_s2_he  <= r_s1_he;
            r_s2_op  <= r_s1_op;
        end
        if (w_en[2]) begin
            r_s3_p   <= n_s3_p;
            r_s3_sd  <= SDW'(r_s2_dsq[0]) + SDW'(r_s2_dsq[1]) + SDW'(r_s2_dsq[2]);
            r_s3_rs2 <= r_s2_rs2;
            r_s3_r2  <= r_s2_r2;
            r_s3_he  <= r_s2_he;
            r_s3_op  <= r_s2_op;
        end
        if (w_en[3]) begin
            r_s4_e       <= n_s4_e;
            r_s4_sph_hit <= SCW'(r_s3_sd) <= SCW'(r_s3_rs2);
            r_s4_r2      <= r_s3_r2;
            r_s4_op      <= r_s3_op;
        end
        if (w_en[4]) begin
            r_s5_hh      <= n_s5_hh;
            r_s5_hl      <= n_s5_hl;
            r_s5_ll      <= n_s5_ll;
            r_s5_sph_hit <= r_s4_sph_hit;
            r_s5_r2      <= r_s4_r2;
            r_s5_op      <= r_s4_op;
        end
        if (w_en[5]) begin
            r_s6_sq      <= n_s6_sq;
            r_s6_sph_hit <= r_s5_sph_hit;
            r_s6_r2      <= r_s5_r2;
            r_s6_op      <= r_s5_op;
        end
        if (w_en[6]) begin
            r_s7_bd      <= BW'(r_s6_sq[0]) + BW'(r_s6_sq[1]) + BW'(r_s6_sq[2]);
            r_s7_sph_hit <= r_s6_sph_hit;
            r_s7_r2      <= r_s6_r2;
            r_s7_op      <= r_s6_op;
        end
        if (w_en[7]) begin
            r_s8_hit <= (r_s7_op == OP_BOX) ? w_box_hit : r_s7_sph_hit;
        end
    end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb : regression bench for the sphere collision test
// Drives overlap questions through the valid/ready question channel, expects
// a typed or predicted hit flag for each accepted word and checks the results.
// ============================================================================
module tb;
    import sct_pkg::*;

    // Clock and run length. The period is 8 ns.
    localparam int CLK_HALF_NS   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int TIMEOUT_NS    = 1_000_000;
    // Random words after the directed rows; the two together make about 550.
    localparam int RANDOM_WORDS  = 527;
    // Pipeline depth given for the block, doubled for the final settle time.
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT   = 5000;
    // Long output hold-off: when it starts and how many cycles it lasts.
    localparam int HOLD_AT       = 120;
    localparam int HOLD_CYCLES   = 120;

    // Lane layout used to build stimulus (default coordinate width).
    localparam int COORD_W = COORD_BITS_DEF;

    // Row kinds of the directed stimulus and the two hit values.
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;
    localparam bit HIT       = 1'b1;
    localparam bit MISS      = 1'b0;

    // Box axes along the world axes, 1.0 in Q1.14.
    localparam logic [FIELD_W-1:0] UNIT_X = 48'h0000_0000_4000;
    localparam logic [FIELD_W-1:0] UNIT_Y = 48'h0000_4000_0000;
    localparam logic [FIELD_W-1:0] UNIT_Z = 48'h4000_0000_0000;

    // One overlap question, field for field as it appears on the ports.
    typedef struct packed {
        logic               opcode;
        logic [FIELD_W-1:0] sphere_center;
        logic [RAD_W-1:0]   sphere_radius;
        logic [FIELD_W-1:0] other_center;
        logic [RAD_W-1:0]   other_radius;
        logic [FIELD_W-1:0] half_extents;
        logic [FIELD_W-1:0] axis_one;
        logic [FIELD_W-1:0] axis_two;
        logic [FIELD_W-1:0] axis_three;
    } t_question;

    // A directed row: the question plus, where it is obvious, the answer.
    typedef struct packed {
        t_question q;
        logic      typed;
        logic      hit;
    } t_stim_row;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    logic      o_out_valid;
    logic      i_out_ready;
    logic      o_hit;

    // The word on offer, with the typed answer that goes with it, if any.
    t_question offered;
    logic      offered_typed;
    logic      offered_hit;

    // Hit flags still owed by the block, oldest first.
    bit        pending_hits[$];
    t_stim_row directed_rows[$];

    int        fail_count         = 0;
    int        questions_accepted = 0;
    int        sphere_questions   = 0;
    int        box_questions      = 0;
    int        hits_seen          = 0;
    int        misses_seen        = 0;

    always #CLK_HALF_NS i_clk = ~i_clk;

    sphere_collision_test_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (offered.opcode),
        .i_sphere_center (offered.sphere_center),
        .i_sphere_radius (offered.sphere_radius),
        .i_other_center  (offered.other_center),
        .i_other_radius  (offered.other_radius),
        .i_half_extents  (offered.half_extents),
        .i_axis_one      (offered.axis_one),
        .i_axis_two      (offered.axis_two),
        .i_axis_three    (offered.axis_three),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit)
    );

    // ------------------------------------------------------------------------
    // Hit prediction
    // ------------------------------------------------------------------------

    // Reads lane idx of width w out of a 48-bit field. Lane bits that fall
    // past the top of the field read as zero.
    function automatic longint lane_value(input logic [FIELD_W-1:0] field,
                                          input int idx, input int w,
                                          input bit is_signed);
        logic [127:0] wide;
        logic [63:0]  bits;
        logic [63:0]  sign_bit;
        wide     = {80'd0, field} >> (idx * w);
        bits     = wide[63:0] & ((64'd1 << w) - 64'd1);
        sign_bit = 64'd1 << (w - 1);
        if (is_signed) begin
            return longint'(bits ^ sign_bit) - longint'(sign_bit);
        end
        return longint'(bits);
    endfunction

    // Exact hit flag of one question. Sphere pairs compare squared center
    // distance with the squared radius sum. Boxes project the relative
    // center on each axis (Q.22), clamp against the half extent moved up by
    // the axis fraction, and compare the squared excess (Q.44) with the
    // squared radius moved up to the same format.
    function automatic bit predict_hit(input t_question q);
        longint             diff[3];
        longint             proj;
        longint             half;
        logic [127:0]       excess;
        logic [127:0]       sum_sq;
        logic [127:0]       radius;
        logic [FIELD_W-1:0] axes[3];
        for (int k = 0; k < 3; k++) begin
            diff[k] = lane_value(q.sphere_center, k, COORD_W, 1'b1)
                    - lane_value(q.other_center, k, COORD_W, 1'b1);
        end
        sum_sq = '0;
        if (q.opcode == OP_SPHERE) begin
            for (int k = 0; k < 3; k++) begin
                excess = 128'((diff[k] < 0) ? -diff[k] : diff[k]);
                sum_sq = sum_sq + excess * excess;
            end
            radius = 128'(q.sphere_radius);
            radius = radius + 128'(q.other_radius);
            return sum_sq <= radius * radius;
        end
        axes = '{q.axis_one, q.axis_two, q.axis_three};
        for (int j = 0; j < 3; j++) begin
            proj = 0;
            for (int k = 0; k < 3; k++) begin
                proj += diff[k] * lane_value(axes[j], k, AXIS_BITS, 1'b1);
            end
            half = lane_value(q.half_extents, j, COORD_W, 1'b0) << AXIS_FRAC;
            if (proj > half) begin
                excess = 128'(proj - half);
            end else if (proj < -half) begin
                excess = 128'(-half - proj);
            end else begin
                excess = '0;
            end
            sum_sq = sum_sq + excess * excess;
        end
        radius = 128'(q.sphere_radius);
        return sum_sq <= ((radius * radius) << LIM_SHIFT);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_stim_row stim_row(input logic op,
                                           input logic [FIELD_W-1:0] sc,
                                           input logic [RAD_W-1:0] sr,
                                           input logic [FIELD_W-1:0] oc,
                                           input logic [RAD_W-1:0] orad,
                                           input logic [FIELD_W-1:0] he,
                                           input logic [FIELD_W-1:0] a1,
                                           input logic [FIELD_W-1:0] a2,
                                           input logic [FIELD_W-1:0] a3,
                                           input bit typed, input bit hit);
        t_stim_row r;
        r.q     = '{op, sc, sr, oc, orad, he, a1, a2, a3};
        r.typed = typed;
        r.hit   = hit;
        return r;
    endfunction

    function automatic logic [FIELD_W-1:0] rand_field();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[FIELD_W-1:0];
    endfunction

    // Signed offset in [-span, span], as a 16-bit lane.
    function automatic logic [15:0] rand_offset(input int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        return v[15:0];
    endfunction

    // Most questions are near misses or near hits: the sphere sits close to
    // the other shape at one of three scales, with radii and half extents of
    // the same scale. Box axes are mostly signed permutations of the world
    // axes, sometimes arbitrary short vectors, sometimes raw bits. The rest
    // is raw noise on every field, which also toggles every input bit.
    function automatic t_question random_question();
        t_question          q;
        int                 span;
        int                 perm[3];
        int                 pick;
        int                 tmp;
        logic [FIELD_W-1:0] axes[3];
        logic [15:0]        unit;
        q.opcode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 15) begin
            q.sphere_center = rand_field();
            q.sphere_radius = RAD_W'($urandom_range(0, 32767));
            q.other_center  = rand_field();
            q.other_radius  = RAD_W'($urandom_range(0, 32767));
            q.half_extents  = rand_field();
            q.axis_one      = rand_field();
            q.axis_two      = rand_field();
            q.axis_three    = rand_field();
            return q;
        end
        case ($urandom_range(0, 3))
            0:       span = 16'h00FF;
            1, 2:    span = 16'h0FFF;
            default: span = 16'h7FFF;
        endcase
        q.other_center = rand_field();
        for (int k = 0; k < 3; k++) begin
            q.sphere_center[16*k +: 16] = q.other_center[16*k +: 16] + rand_offset(span);
            q.half_extents[16*k +: 16]  = 16'($urandom_range(0, span));
        end
        q.sphere_radius = RAD_W'($urandom_range(0, span));
        q.other_radius  = RAD_W'($urandom_range(0, span));
        case ($urandom_range(0, 3))
            0, 1: begin
                perm = '{0, 1, 2};
                for (int j = 2; j > 0; j--) begin
                    pick       = $urandom_range(0, j);
                    tmp        = perm[j];
                    perm[j]    = perm[pick];
                    perm[pick] = tmp;
                end
                for (int j = 0; j < 3; j++) begin
                    unit    = $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
                    axes[j] = {32'd0, unit} << (16 * perm[j]);
                end
            end
            2: begin
                for (int j = 0; j < 3; j++) begin
                    for (int k = 0; k < 3; k++) begin
                        axes[j][16*k +: 16] = rand_offset(16'h4000);
                    end
                end
            end
            default: begin
                axes = '{rand_field(), rand_field(), rand_field()};
            end
        endcase
        q.axis_one   = axes[0];
        q.axis_two   = axes[1];
        q.axis_three = axes[2];
        return q;
    endfunction

    // Puts one word on the question channel and returns at the edge where it
    // is taken. Valid stays high afterwards; the caller lowers it for a gap.
    task automatic offer(input t_question q, input bit typed, input bit hit);
        offered       <= q;
        offered_typed <= typed;
        offered_hit   <= hit;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic idle_cycles(input int n);
        i_in_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Result channel: stall pattern and long hold-off
    // ------------------------------------------------------------------------

    // The receiver cycles through four moods of equal length: always ready,
    // mostly ready, mostly stalled, and strictly alternating. Once, after
    // HOLD_AT questions have gone in, it refuses results throughout a hold-off
    // of length HOLD_CYCLES so that the pipeline fills and pushes back.
    initial begin
        int  cycle;
        int  hold_left;
        bit  held_once;
        bit  ready_next;
        cycle       = 0;
        hold_left   = 0;
        held_once   = 1'b0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            cycle++;
            if (!held_once && questions_accepted >= HOLD_AT) begin
                held_once = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else begin
                case ((cycle / 48) % 4)
                    0:       ready_next = 1'b1;
                    1:       ready_next = ($urandom_range(0, 3) != 0);
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = cycle[0];
                endcase
            end
            i_out_ready <= ready_next;
        end
    end

    // ------------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------------

    // Both handshakes are sampled at the rising edge, before any nonblocking
    // update of that edge lands. An accepted question is logged before the
    // result of the same edge is checked, so even an answer that came back at once would
    // find its expectation waiting.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_hits.push_back(offered_typed ? offered_hit : predict_hit(offered));
                questions_accepted++;
                if (offered.opcode == OP_BOX) begin
                    box_questions++;
                end else begin
                    sphere_questions++;
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_hits.size() == 0) begin
                    $error("result word with no question outstanding: hit=%0b", o_hit);
                    fail_count++;
                end else begin
                    want = pending_hits.pop_front();
                    if (o_hit !== want) begin
                        $error("field hit: expected %0b, actual %0b", want, o_hit);
                        fail_count++;
                    end
                    if (want) begin
                        hits_seen++;
                    end else begin
                        misses_seen++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin
        int burst_left;
        int gap;
        int drain_wait;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        offered       = '0;
        offered_typed = 1'b0;
        offered_hit   = 1'b0;

        // Sphere pairs: coincident points, opposite corners of the
        // coordinate range with the largest radii, exact touching and one
        // LSB apart, and box fields that must be ignored.
        directed_rows.push_back(stim_row(OP_SPHERE, '0, '0, '0, '0, '0, '0, '0, '0,
                                         TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h8000_8000_8000, 15'h7FFF,
                                         48'h7FFF_7FFF_7FFF, 15'h7FFF, '0, '0, '0, '0,
                                         TYPED, MISS));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0000_0000_8000, 15'h7FFF,
                                         48'h0000_0000_7FFF, 15'h7FFF, '0, '0, '0, '0,
                                         TYPED, MISS));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0000_0000_8000, 15'h7FFF,
                                         48'h0000_0000_7FFE, 15'h7FFF, '0, '0, '0, '0,
                                         TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0000_0000_0200, 15'h0100,
                                         '0, 15'h0100, '0, '0, '0, '0, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0000_0000_0201, 15'h0100,
                                         '0, 15'h0100, '0, '0, '0, '0, TYPED, MISS));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h7FFF_7FFF_7FFF, '0,
                                         48'h7FFF_7FFF_7FFF, '0, '0, '0, '0, '0,
                                         TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0200_0000_0000, 15'h0100,
                                         '0, 15'h0100, '1, '1, '1, '1, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, '1, 15'h7FFF, '1, 15'h7FFF,
                                         '1, '1, '1, '1, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_SPHERE, 48'h0123_FEDC_4567, 15'h0080,
                                         48'h0100_FF00_4500, 15'h0100, '0, '0, '0, '0,
                                         PREDICTED, MISS));

        // Boxes: zero axes make every projection vanish, a point box at the
        // sphere, touching faces on both sides and one LSB short, the widest
        // box, the most negative axes, the other radius being ignored, and
        // axes that are neither orthogonal nor unit length.
        directed_rows.push_back(stim_row(OP_BOX, 48'h7FFF_8000_7FFF, '0, '0, '0,
                                         '0, '0, '0, '0, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h1234_5678_9ABC, '0,
                                         48'h1234_5678_9ABC, '0, '0,
                                         UNIT_X, UNIT_Y, UNIT_Z, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0000_0200, 15'h0100, '0, '0,
                                         48'h0100_0100_0100, UNIT_X, UNIT_Y, UNIT_Z,
                                         TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0000_0200, 15'h00FF, '0, '0,
                                         48'h0100_0100_0100, UNIT_X, UNIT_Y, UNIT_Z,
                                         TYPED, MISS));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0000_FE00, 15'h0100, '0, '0,
                                         48'h0100_0100_0100, UNIT_X, UNIT_Y, UNIT_Z,
                                         TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h7FFF_7FFF_7FFF, '0,
                                         48'h8000_8000_8000, '0, '1,
                                         UNIT_X, UNIT_Y, UNIT_Z, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h7FFF_7FFF_7FFF, 15'h7FFF,
                                         48'h8000_8000_8000, '0, '0, 48'h8000_8000_8000,
                                         48'h8000_8000_8000, 48'h8000_8000_8000,
                                         TYPED, MISS));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0000_0001, '0, '0, 15'h7FFF,
                                         '0, UNIT_X, UNIT_Y, UNIT_Z, TYPED, MISS));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0000_0001, 15'h0001, '0, '0,
                                         '0, UNIT_X, UNIT_Y, UNIT_Z, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, '0, 15'h7FFF, '0, '0, '0,
                                         UNIT_X, UNIT_Y, UNIT_Z, TYPED, HIT));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0300_0180, 15'h0080, '0, '0,
                                         48'h0100_0100_0100, UNIT_X, UNIT_X, UNIT_X,
                                         PREDICTED, MISS));
        directed_rows.push_back(stim_row(OP_BOX, 48'h0000_0150_0150, 15'h0040, '0, '0,
                                         48'h0080_0080_0080, 48'h0000_2D41_2D41,
                                         48'h0000_2D41_D2BF, UNIT_Z, PREDICTED, MISS));
        directed_rows.push_back(stim_row(OP_BOX, '1, 15'h7FFF, '1, 15'h7FFF,
                                         '1, '1, '1, '1, PREDICTED, MISS));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows go in back to back; the receiver pattern alone
        // decides how fast they drain.
        foreach (directed_rows[n]) begin
            offer(directed_rows[n].q, directed_rows[n].typed, directed_rows[n].hit);
        end

        // Random words come in bursts separated by gaps. Halfway through,
        // the sender stops and waits for every answer to come back, so the
        // pipeline is seen empty and then restarted.
        burst_left = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == RANDOM_WORDS / 2) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_hits.size() != 0) @(posedge i_clk);
            end else if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                         : $urandom_range(1, 12);
                gap        = $urandom_range(0, 8);
                if (gap > 0) begin
                    idle_cycles(gap);
                end
            end
            offer(random_question(), PREDICTED, MISS);
            if (burst_left > 0) begin
                burst_left--;
            end
        end
        i_in_valid <= 1'b0;

        // Wait for the last answers, then a little longer so that any stray
        // extra word would still be caught.
        drain_wait = 0;
        while (pending_hits.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_hits.size() != 0) begin
            $error("%0d result words never arrived", pending_hits.size());
            fail_count++;
        end

        $display("Run covered %0d questions (%0d sphere pairs, %0d boxes), %0d directed.",
                 questions_accepted, sphere_questions, box_questions, directed_rows.size());
        $display("Answers compared: %0d touching, %0d apart; %0d mismatches.",
                 hits_seen, misses_seen, fail_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Safety net in case a handshake never completes.
    initial begin
        #TIMEOUT_NS;
        $display("Timed out after %0d ns with %0d answers outstanding.",
                 TIMEOUT_NS, pending_hits.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sphere_collision_test_top.f @@
src/sct_pkg.sv
src/sphere_collision_test_top.sv
tb/sv/tb.sv
